### rtl/dstq_pkg.sv
package dstq_pkg;

	localparam int QueueDepthDefault = 16;
	localparam int IdBitsDefault = 8;
	localparam int MaxResults = 16;
	localparam logic [31:0] INFINITE = 32'hFFFF_FFFF;

	localparam logic [1:0] REQ_POST = 2'd0;
	localparam logic [1:0] REQ_SIGNAL = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;
	localparam logic [1:0] REQ_SHUTDOWN = 2'd3;

	localparam logic [1:0] CODE_TIMEOUT = 2'd0;
	localparam logic [1:0] CODE_SIGNAL = 2'd1;
	localparam logic [1:0] CODE_ABORT = 2'd2;
	localparam logic [1:0] CODE_FULL = 2'd3;

	typedef struct packed {
		logic [7:0] id;
		logic [1:0] code;
		logic last;
	} result_t;

	// True when a - b, read as a signed 32-bit value, is negative.
	function automatic logic diff_negative(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

endpackage

### rtl/dstq_mem.sv
module dstq_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 41
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/dstq_out.sv
module dstq_out (
	input logic clk,
	input logic arst_n,
	input logic push,
	input dstq_pkg::result_t push_res,
	output logic free,
	output logic done_valid,
	input logic done_stall,
	output logic [7:0] done_id,
	output logic [1:0] completion_code,
	output logic last_of_run
);
	import dstq_pkg::*;

	result_t res_q;

	// A new item may be loaded when the register is empty or drains this cycle.
	assign free = !done_valid || !done_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_valid <= 1'b0;
		end else if (free) begin
			done_valid <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (free && push) begin
			res_q <= push_res;
		end
	end

	assign done_id = res_q.id;
	assign completion_code = res_q.code;
	assign last_of_run = res_q.last;
endmodule

### rtl/deadline_sorted_timer_queue_top.sv
// Deadline-sorted timer queue.
// Request channel (req_valid/req_stall): req_type, op_id, deadline, now_tick.
// Completion channel (done_valid/done_stall): done_id, completion_code and
// last_of_run, which marks the final completion caused by one request item.
// Entries live in one single-port-write synchronous memory, kept packed from
// slot 0. Every request that is not an immediate or rejected post walks the
// stored entries once in slot order, each occupied slot read, then modified
// and written back; a shutdown walks again over the entries left after the
// first pass. Entries are read one at a time through the one memory read
// port. One request item is worked on at a time; req_stall is high from
// acceptance until its last completion, if any, is loaded into the output
// register, which shows it on done_valid from the following cycle.
// Reset empties the queue at once; no memory clearing pass is needed since
// only slots below the count are ever read. When the receiver stalls, the
// walk pauses with its completion held and the memory left unchanged.
module deadline_sorted_timer_queue_top #(
	parameter int QUEUE_DEPTH = dstq_pkg::QueueDepthDefault,
	parameter int ID_BITS = dstq_pkg::IdBitsDefault
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic [1:0] req_type,
	input logic [7:0] op_id,
	input logic [31:0] deadline,
	input logic [31:0] now_tick,
	output logic done_valid,
	input logic done_stall,
	output logic [7:0] done_id,
	output logic [1:0] completion_code,
	output logic last_of_run
);
	import dstq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(MaxResults + 1);
	localparam int EW = 32 + ID_BITS + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_PR, ST_FIN} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] w_q;
	logic [NW-1:0] n_q;
	logic [1:0] req_q;
	logic [ID_BITS-1:0] id_q;
	logic [31:0] dl_q;
	logic [31:0] now_q;
	logic post_ins_q;
	logic post_held_q;
	logic ins_q;
	logic stop_q;
	logic found_q;
	logic phase2_q;
	logic [EW-1:0] carry_q;
	logic pend_v_q;
	result_t pend_q;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic mem_re;
	logic [EW-1:0] rdata;
	logic out_free;
	logic push;
	result_t push_res;

	logic [31:0] e_dl;
	logic [ID_BITS-1:0] e_own;
	logic e_held;
	logic n_ok;
	logic rem;
	logic ins_here;
	logic [1:0] rem_code;
	logic [EW-1:0] new_entry;

	assign e_dl = rdata[31:0];
	assign e_own = rdata[32 +: ID_BITS];
	assign e_held = rdata[EW-1];
	assign n_ok = n_q < NW'(MaxResults);
	assign new_entry = {post_held_q, id_q, dl_q};
	assign req_stall = state_q != ST_IDLE;
	assign mem_re = state_q == ST_RD && j_q != count_q;

	// Decide what happens to the entry just read.
	always_comb begin
		rem = 1'b0;
		rem_code = CODE_TIMEOUT;
		unique case (req_q)
			REQ_SIGNAL: begin
				rem = !found_q && e_own == id_q;
				rem_code = CODE_SIGNAL;
			end
			REQ_TICK: begin
				rem = !e_held && !stop_q && n_ok && !diff_negative(now_q, e_dl);
				rem_code = CODE_TIMEOUT;
			end
			REQ_SHUTDOWN: begin
				rem = n_ok && (phase2_q || !e_held);
				rem_code = CODE_ABORT;
			end
			default: begin
				rem = 1'b0;
				rem_code = CODE_TIMEOUT;
			end
		endcase
		ins_here = !ins_q && !post_held_q && !e_held && !diff_negative(e_dl, dl_q);
	end

	// Memory write port and completion pushes.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = j_q[AW-1:0];
		mem_wdata = rdata;
		push = 1'b0;
		push_res = pend_q;
		unique case (state_q)
			ST_PR: begin
				if (req_q == REQ_POST) begin
					mem_we = out_free && (ins_here || ins_q);
					mem_waddr = j_q[AW-1:0];
					mem_wdata = ins_here ? new_entry : carry_q;
				end else begin
					mem_we = out_free && !rem;
					mem_waddr = w_q[AW-1:0];
					mem_wdata = rdata;
					push = rem && pend_v_q;
					push_res.last = 1'b0;
				end
			end
			ST_FIN: begin
				mem_we = out_free && post_ins_q;
				mem_waddr = count_q[AW-1:0];
				mem_wdata = ins_q ? carry_q : new_entry;
				push = pend_v_q;
				push_res.last = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			j_q <= '0;
			w_q <= '0;
			n_q <= '0;
			req_q <= REQ_POST;
			post_ins_q <= 1'b0;
			post_held_q <= 1'b0;
			ins_q <= 1'b0;
			stop_q <= 1'b0;
			found_q <= 1'b0;
			phase2_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q <= req_type;
						id_q <= ID_BITS'(op_id);
						dl_q <= deadline;
						now_q <= now_tick;
						j_q <= '0;
						w_q <= '0;
						n_q <= '0;
						ins_q <= 1'b0;
						stop_q <= 1'b0;
						found_q <= 1'b0;
						phase2_q <= 1'b0;
						post_held_q <= deadline == INFINITE;
						post_ins_q <= 1'b0;
						pend_q.id <= 8'(ID_BITS'(op_id));
						pend_q.last <= 1'b1;
						if (req_type == REQ_POST && deadline == '0) begin
							pend_v_q <= 1'b1;
							pend_q.code <= CODE_SIGNAL;
							state_q <= ST_FIN;
						end else if (req_type == REQ_POST &&
								count_q == CW'(QUEUE_DEPTH)) begin
							pend_v_q <= 1'b1;
							pend_q.code <= CODE_FULL;
							state_q <= ST_FIN;
						end else begin
							pend_v_q <= 1'b0;
							post_ins_q <= req_type == REQ_POST;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					if (j_q != count_q) begin
						state_q <= ST_PR;
					end else if (req_q == REQ_POST) begin
						state_q <= ST_FIN;
					end else begin
						count_q <= w_q;
						if (req_q == REQ_SHUTDOWN && !phase2_q) begin
							// Timed entries are gone unless the result limit was hit; now abort the held ones.
							phase2_q <= 1'b1;
							j_q <= '0;
							w_q <= '0;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_PR: begin
					if (out_free) begin
						j_q <= j_q + 1'b1;
						state_q <= ST_RD;
						if (req_q == REQ_POST) begin
							if (ins_here || ins_q) begin
								carry_q <= rdata;
								ins_q <= 1'b1;
							end
						end else if (rem) begin
							pend_v_q <= 1'b1;
							pend_q.id <= 8'(e_own);
							pend_q.code <= rem_code;
							n_q <= n_q + 1'b1;
							found_q <= 1'b1;
						end else begin
							w_q <= w_q + 1'b1;
							if (!e_held) begin
								stop_q <= 1'b1;
							end
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						if (post_ins_q) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	dstq_mem #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(EW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(j_q[AW-1:0]),
		.rdata(rdata)
	);

	dstq_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_res(push_res),
		.free(out_free),
		.done_valid(done_valid),
		.done_stall(done_stall),
		.done_id(done_id),
		.completion_code(completion_code),
		.last_of_run(last_of_run)
	);
endmodule
